@@ design/utf8_stream_validator_top_defines.svh @@
// Assertion macros shared by the UTF-8 stream validator RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef UTF8_STREAM_VALIDATOR_TOP_DEFINES_SVH
`define UTF8_STREAM_VALIDATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define U8SV_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define U8SV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/u8sv_pkg.sv @@
// Package for the UTF-8 stream validator: transaction payload types and
// the byte and codepoint constants used by the decode logic. No dependencies.
package u8sv_pkg;

  localparam int OWED_W = 3;
  localparam int CP_W   = 31;

  // Leads whose first continuation byte has a lower bound against overlong forms.
  localparam logic [7:0] LEAD_E0 = 8'he0;
  localparam logic [7:0] LEAD_F0 = 8'hf0;
  localparam logic [7:0] LEAD_F8 = 8'hf8;
  localparam logic [7:0] LEAD_FC = 8'hfc;
  localparam logic [7:0] MIN_E0  = 8'ha0;
  localparam logic [7:0] MIN_F0  = 8'h90;
  localparam logic [7:0] MIN_F8  = 8'h88;
  localparam logic [7:0] MIN_FC  = 8'h84;

  // Bits of a two-byte lead that must not all be zero (C0 and C1 are overlong).
  localparam logic [7:0] TWO_BYTE_MASK = 8'h1e;

  localparam logic [CP_W-1:0] SURR_MASK = 31'h7fff_f800;
  localparam logic [CP_W-1:0] SURR_BASE = 31'h0000_d800;
  localparam logic [CP_W-1:0] CP_MAX    = 31'h0010_ffff;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_buffer;
    logic       last_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic              valid_so_far;
    logic              verdict_final;
    logic              terminated;
    logic [OWED_W-1:0] pending_continuations;
  } out_item_t;

endpackage

@@ design/u8sv_core.sv @@
// Per-byte UTF-8 decode state and next-state logic for the stream validator.
// Depends on u8sv_pkg and the assertion macros in the top-level defines header.
`include "utf8_stream_validator_top_defines.svh"

module u8sv_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  u8sv_pkg::in_item_t   item,
  output u8sv_pkg::out_item_t  result
);

  logic [u8sv_pkg::OWED_W-1:0] owed_r, owed_nxt, owed_b, owed_dec;
  logic [7:0]                  lead_r, lead_nxt, lead_b;
  logic [u8sv_pkg::CP_W-1:0]   cp_r, cp_nxt, cp_b, cp_shift;
  logic                        err_r, err_nxt, err_b;
  logic                        nul_r, nul_nxt, nul_b;

  logic [7:0]                  c;
  logic [u8sv_pkg::OWED_W-1:0] lead_n;
  logic [6:0]                  lead_bits;
  logic                        lead_ok;
  logic                        overlong, bad_cont, cp_bad;

  assign c = item.data_byte;

  // A new buffer starts from the reset state.
  always_comb begin
    if (item.first_of_buffer) begin
      owed_b = '0;
      lead_b = '0;
      cp_b   = '0;
      err_b  = 1'b0;
      nul_b  = 1'b0;
    end else begin
      owed_b = owed_r;
      lead_b = lead_r;
      cp_b   = cp_r;
      err_b  = err_r;
      nul_b  = nul_r;
    end
  end

  // Lead byte classification by its run of leading ones.
  always_comb begin
    lead_ok   = 1'b1;
    lead_n    = '0;
    lead_bits = c[6:0];
    if (!c[7]) begin
      lead_n    = 3'd0;
      lead_bits = c[6:0];
    end else if (c[7:5] == 3'b110) begin
      lead_n    = 3'd1;
      lead_bits = {2'b00, c[4:0]};
    end else if (c[7:4] == 4'b1110) begin
      lead_n    = 3'd2;
      lead_bits = {3'b000, c[3:0]};
    end else if (c[7:3] == 5'b11110) begin
      lead_n    = 3'd3;
      lead_bits = {4'b0000, c[2:0]};
    end else if (c[7:2] == 6'b111110) begin
      lead_n    = 3'd4;
      lead_bits = {5'b00000, c[1:0]};
    end else if (c[7:1] == 7'b1111110) begin
      lead_n    = 3'd5;
      lead_bits = {6'b000000, c[0]};
    end else begin
      lead_ok   = 1'b0;
    end
  end

  always_comb begin
    overlong = ((lead_b == u8sv_pkg::LEAD_E0) && (owed_b == 3'd2) && (c < u8sv_pkg::MIN_E0)) ||
               ((lead_b == u8sv_pkg::LEAD_F0) && (owed_b == 3'd3) && (c < u8sv_pkg::MIN_F0)) ||
               ((lead_b == u8sv_pkg::LEAD_F8) && (owed_b == 3'd4) && (c < u8sv_pkg::MIN_F8)) ||
               ((lead_b == u8sv_pkg::LEAD_FC) && (owed_b == 3'd5) && (c < u8sv_pkg::MIN_FC));
    bad_cont = (c[7:6] != 2'b10);
    cp_shift = {cp_b[u8sv_pkg::CP_W-7:0], c[5:0]};
    owed_dec = owed_b - 3'd1;
    cp_bad   = (cp_shift == '0) ||
               ((cp_shift & u8sv_pkg::SURR_MASK) == u8sv_pkg::SURR_BASE) ||
               (cp_shift > u8sv_pkg::CP_MAX);
  end

  always_comb begin
    owed_nxt = owed_b;
    lead_nxt = lead_b;
    cp_nxt   = cp_b;
    err_nxt  = err_b;
    nul_nxt  = nul_b;
    if (!nul_b) begin
      if (c == 8'h00) begin
        nul_nxt = 1'b1;
      end else if (owed_b == '0) begin
        if (!lead_ok) begin
          err_nxt  = 1'b1;
          owed_nxt = '0;
        end else begin
          lead_nxt = c;
          cp_nxt   = {24'b0, lead_bits};
          owed_nxt = lead_n;
          if ((lead_n == 3'd1) && ((c & u8sv_pkg::TWO_BYTE_MASK) == 8'h00)) begin
            err_nxt  = 1'b1;
            owed_nxt = '0;
          end
        end
      end else if (overlong || bad_cont) begin
        err_nxt  = 1'b1;
        owed_nxt = '0;
      end else begin
        cp_nxt   = cp_shift;
        owed_nxt = owed_dec;
        if ((owed_dec == '0) && cp_bad) begin
          err_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owed_r <= '0;
      lead_r <= '0;
      cp_r   <= '0;
      err_r  <= 1'b0;
      nul_r  <= 1'b0;
    end else if (step_en) begin
      owed_r <= owed_nxt;
      lead_r <= lead_nxt;
      cp_r   <= cp_nxt;
      err_r  <= err_nxt;
      nul_r  <= nul_nxt;
    end
  end

  always_comb begin
    result.valid_so_far          = !err_nxt;
    result.verdict_final         = item.last_of_buffer;
    result.terminated            = nul_nxt;
    result.pending_continuations = owed_nxt;
  end

  // An error holds until a new buffer starts.
  `U8SV_ASSERT_NEXT(a_err_sticky, step_en && !item.first_of_buffer && err_r, err_r, "error flag cleared without a new buffer")
  // After a NUL, bytes of the same buffer leave the decode state alone.
  `U8SV_ASSERT_NEXT(a_nul_freeze, step_en && !item.first_of_buffer && nul_r, $stable(owed_r) && $stable(cp_r) && nul_r, "state changed after NUL")
  // A reported result reflects the state that the step commits.
  `U8SV_ASSERT_NEXT(a_commit, step_en, (owed_r == $past(result.pending_continuations)) && (err_r != $past(result.valid_so_far)), "committed state differs from result")

endmodule

@@ design/utf8_stream_validator_top.sv @@
// Top level of the UTF-8 stream validator: input register, decode core and
// result register. Depends on u8sv_pkg and u8sv_core.
//
//   Channel  Ports                          Payload type          Direction
//   input    in_valid, in_ready, in_data    u8sv_pkg::in_item_t   into block
//   result   out_valid, out_ready, out_data u8sv_pkg::out_item_t  out of block
//
// The block takes one byte per cycle while the result channel is not stalled
// and returns one result per byte, in order. A result is offered after its
// byte is accepted: the byte is first loaded into the input register; when it
// moves on, the decode core runs, updates its state and loads the result
// register. Reset is synchronous on rst_n and clears both valid flags and the
// decode state. When out_ready is low with a result waiting, the input register
// still accepts one transaction and then holds it until the result moves.

module utf8_stream_validator_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  u8sv_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u8sv_pkg::out_item_t  out_data
);

  // Input stage: holds one accepted byte until the core can process it.
  logic                 s1_valid_r;
  u8sv_pkg::in_item_t   s1_item_r;

  // Result stage: holds one finished result until the consumer takes it.
  logic                 out_valid_r;
  u8sv_pkg::out_item_t  out_item_r;

  u8sv_pkg::out_item_t  core_result;
  logic                 s1_adv;

  // The byte in the input stage moves on when the result register is empty or
  // is being emptied in this same cycle. The decode state advances only then,
  // so each byte updates it exactly once.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  u8sv_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_adv),
    .item    (s1_item_r),
    .result  (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item_r <= core_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
